FILE: rtl/dtcc_pkg.sv
`timescale 1ns / 1ps

package dtcc_pkg;

  localparam int unsigned MAG_W   = 31;
  localparam int unsigned FRAC_W  = 4;
  localparam int unsigned MANT_W  = 32;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [FRAC_W-1:0] MAX_FRACTION_DIGITS = FRAC_W'(9);
  localparam logic [MAG_W-1:0]  MAG_LIMIT = {MAG_W{1'b1}};

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    K_DIGIT,
    K_POINT,
    K_MINUS,
    K_PLUS,
    K_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    CLS_INTEGER = 2'd0,
    CLS_DECIMAL = 2'd1,
    CLS_TEXT    = 2'd2
  } cls_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } chr_word_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/dtcc_front.sv
`timescale 1ns / 1ps

module dtcc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,
  input  logic                      in_tlast,
  input  dtcc_pkg::q_stat_t         q_stat,
  output logic                      push,
  output dtcc_pkg::chr_word_t       word
);
  import dtcc_pkg::*;

  logic      front_v_r, front_v_nxt;
  chr_word_t word_r, word_nxt;
  logic      take;

  assign push      = front_v_r && !q_stat.full;
  assign in_tready = !front_v_r || !q_stat.full;
  assign take      = in_tvalid && in_tready;
  assign word      = word_r;

  always_comb begin
    word_nxt.last  = in_tlast;
    word_nxt.digit = in_tdata[3:0];
    if (in_tdata >= CH_ZERO && in_tdata <= CH_NINE) begin
      word_nxt.kind = K_DIGIT;
    end else if (in_tdata == CH_POINT) begin
      word_nxt.kind = K_POINT;
    end else if (in_tdata == CH_MINUS) begin
      word_nxt.kind = K_MINUS;
    end else if (in_tdata == CH_PLUS) begin
      word_nxt.kind = K_PLUS;
    end else begin
      word_nxt.kind = K_OTHER;
    end
  end

  always_comb begin
    if (take) begin
      front_v_nxt = 1'b1;
    end else if (push) begin
      front_v_nxt = 1'b0;
    end else begin
      front_v_nxt = front_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end

endmodule

FILE: rtl/dtcc_queue.sv
`timescale 1ns / 1ps

module dtcc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  dtcc_pkg::q_req_t    req,
  input  dtcc_pkg::chr_word_t wr_word,
  output dtcc_pkg::q_stat_t   stat,
  output dtcc_pkg::chr_word_t rd_word
);
  import dtcc_pkg::*;

  chr_word_t         mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = req.push && !stat.full;
  assign do_pop     = req.pop && !stat.empty;
  assign rd_word    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_word;
    end
  end

endmodule

FILE: rtl/dtcc_back.sv
`timescale 1ns / 1ps

module dtcc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dtcc_pkg::q_stat_t          q_stat,
  input  dtcc_pkg::chr_word_t        word,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dtcc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                 out_tuser
);
  import dtcc_pkg::*;

  logic               start_r, start_nxt;
  logic               neg_r, neg_nxt;
  logic               body_r, body_nxt;
  logic               point_r, point_nxt;
  logic               bad_r, bad_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic               sat_r, sat_nxt;

  logic               out_v_r, out_v_nxt;
  cls_t               cls_r, cls_nxt;
  logic [MANT_W-1:0]  mant_r, mant_nxt;
  logic [FRAC_W-1:0]  ofrac_r, ofrac_nxt;
  logic               ovf_r, ovf_nxt;

  logic [MAG_W+3:0]   prod;
  logic               add_en;
  logic               emit;

  assign pop  = !q_stat.empty && (!word.last || !out_v_r || out_tready);
  assign emit = pop && word.last;

  assign prod = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1) + {(MAG_W)'(0), word.digit};

  always_comb begin
    start_nxt = start_r;
    neg_nxt   = neg_r;
    body_nxt  = body_r;
    point_nxt = point_r;
    bad_nxt   = bad_r;
    mag_nxt   = mag_r;
    frac_nxt  = frac_r;
    sat_nxt   = sat_r;
    add_en    = 1'b0;

    if (pop) begin
      start_nxt = 1'b0;
      if (start_r && (word.kind == K_MINUS || word.kind == K_PLUS)) begin
        neg_nxt = (word.kind == K_MINUS);
      end else begin
        body_nxt = 1'b1;
        unique case (word.kind)
          K_DIGIT: begin
            if (!point_r) begin
              add_en = 1'b1;
            end else if (frac_r < MAX_FRACTION_DIGITS) begin
              add_en   = 1'b1;
              frac_nxt = frac_r + FRAC_W'(1);
            end
          end
          K_POINT: begin
            if (point_r) begin
              bad_nxt = 1'b1;
            end else begin
              point_nxt = 1'b1;
            end
          end
          default: begin
            bad_nxt = 1'b1;
          end
        endcase
      end
      if (add_en) begin
        if (prod > {4'd0, MAG_LIMIT}) begin
          mag_nxt = MAG_LIMIT;
          sat_nxt = 1'b1;
        end else begin
          mag_nxt = prod[MAG_W-1:0];
        end
      end
    end
  end

  // result from the updated token state
  always_comb begin
    cls_nxt   = cls_r;
    mant_nxt  = mant_r;
    ofrac_nxt = ofrac_r;
    ovf_nxt   = ovf_r;
    if (emit) begin
      if (bad_nxt || !body_nxt) begin
        cls_nxt = CLS_TEXT;
      end else if (point_nxt) begin
        cls_nxt = CLS_DECIMAL;
      end else begin
        cls_nxt = CLS_INTEGER;
      end
      if (cls_nxt == CLS_TEXT) begin
        mant_nxt  = '0;
        ofrac_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        mant_nxt  = neg_nxt ? MANT_W'(0) - {1'b0, mag_nxt} : {1'b0, mag_nxt};
        ofrac_nxt = (cls_nxt == CLS_DECIMAL) ? frac_nxt : '0;
        ovf_nxt   = sat_nxt;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      start_r <= 1'b1;
      neg_r   <= 1'b0;
      body_r  <= 1'b0;
      point_r <= 1'b0;
      bad_r   <= 1'b0;
      mag_r   <= '0;
      frac_r  <= '0;
      sat_r   <= 1'b0;
    end else begin
      start_r <= start_nxt;
      neg_r   <= neg_nxt;
      body_r  <= body_nxt;
      point_r <= point_nxt;
      bad_r   <= bad_nxt;
      mag_r   <= mag_nxt;
      frac_r  <= frac_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r   <= cls_nxt;
    mant_r  <= mant_nxt;
    ofrac_r <= ofrac_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = cls_r;
  assign out_tdata  = {{(OUT_TDATA_W - MANT_W - FRAC_W - 1){1'b0}}, ovf_r, ofrac_r, mant_r};

endmodule

FILE: rtl/decimal_token_classify_convert.sv
`timescale 1ns / 1ps
// Decimal token parser. Characters of one token stream in on the in_ side, one
// byte per word, with in_tlast on the final character. One result word leaves
// on the out_ side per token: class in out_tuser (integer, decimal, text),
// signed mantissa, kept fraction digits and overflow flag in out_tdata.
// Value = mantissa / 10^fraction_digits; text tokens give all zeros.
// Throughput: one character per cycle, except while a final character waits on
// a held result. The limit is the back-end accumulate step (magnitude * 10 +
// digit, clamped), one digit per cycle. A token's last character passes the
// front register, the queue, then read and accumulate into the output register.
// A four-word queue sits between the classifying front end and the
// accumulator. When out_tready is low the result is held; the back end keeps
// consuming non-final characters, then stops at the next final one, the queue
// fills and in_tready drops.
// Reset (rst_n low, synchronous) empties the queue, drops any partial token
// and clears the output valid.
module decimal_token_classify_convert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // token_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] mantissa, [35:32] fraction_digits, [36] overflow
  output logic [1:0]  out_tuser   // [1:0] token_class
);
  import dtcc_pkg::*;

  q_stat_t   q_stat;
  q_req_t    q_req;
  chr_word_t front_word;
  chr_word_t back_word;
  logic      push;
  logic      pop;

  assign q_req.push = push;
  assign q_req.pop  = pop;

  dtcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .word      (front_word)
  );

  dtcc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (q_req),
    .wr_word (front_word),
    .stat    (q_stat),
    .rd_word (back_word)
  );

  dtcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .word       (back_word),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/dtcc_checker.sv
`timescale 1ns / 1ps

module dtcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import dtcc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word dropped or changed while stalled");

  a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CLS_TEXT |-> out_tdata == '0)
    else $error("text token carries nonzero number fields");

  a_int_nofrac: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CLS_INTEGER |-> out_tdata[35:32] == '0)
    else $error("integer token with fraction digits");

  a_frac_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[35:32] <= MAX_FRACTION_DIGITS && out_tdata[39:37] == '0)
    else $error("fraction digit count beyond limit or padding set");

  a_ovf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[36] |->
      (out_tdata[31:0] == 32'h7FFF_FFFF || out_tdata[31:0] == 32'h8000_0001))
    else $error("overflow flagged without clamped mantissa");

endmodule

bind decimal_token_classify_convert dtcc_checker u_dtcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dtcc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_WORDS = 1450;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct {
    cls_t        cls;
    logic [31:0] mant;
    logic [3:0]  frac;
    logic        ovf;
  } token_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] character
  logic        in_tlast = 1'b0; // token_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] mantissa, [35:32] fraction_digits, [36] overflow
  logic [1:0]  out_tuser;       // [1:0] token_class

  char_word_t    char_q[$];
  logic [7:0]    tok_buf[$];
  token_result_t token_results_q[$];

  int total_words = 0;
  int words_sent = 0;
  int errors = 0;
  int stall_cycles = 0;

  // parser shadow state
  logic        at_start = 1'b1;
  logic        neg = 1'b0;
  logic        body = 1'b0;
  logic        point = 1'b0;
  logic        bad = 1'b0;
  logic [30:0] mag = '0;
  logic [3:0]  frac_cnt = '0;
  logic        sat = 1'b0;

  decimal_token_classify_convert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (total_words == 0) ? 2 : (words_sent * 3) / total_words;
    case (phase)
      0: idle_pct = sender ? 9 : 86;
      1: idle_pct = sender ? 86 : 9;
      default: idle_pct = 0;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    rand_digit = CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic accumulate_digit(input logic [3:0] d);
    logic [34:0] nxt;
    nxt = {4'b0, mag} * 35'd10 + 35'(d);
    if (nxt > 35'(MAG_LIMIT)) begin
      mag = MAG_LIMIT;
      sat = 1'b1;
    end else begin
      mag = nxt[30:0];
    end
  endtask

  task automatic parse_char(input logic [7:0] ch, input logic last);
    token_result_t res;
    if (at_start && (ch == CH_MINUS || ch == CH_PLUS)) begin
      neg = (ch == CH_MINUS);
    end else begin
      body = 1'b1;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (!point) begin
          accumulate_digit(4'(ch - CH_ZERO));
        end else if (frac_cnt < MAX_FRACTION_DIGITS) begin
          accumulate_digit(4'(ch - CH_ZERO));
          frac_cnt = frac_cnt + 4'd1;
        end
      end else if (ch == CH_POINT) begin
        if (point) bad = 1'b1;
        else point = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end
    at_start = 1'b0;
    if (last) begin
      res.mant = '0;
      res.frac = '0;
      res.ovf = 1'b0;
      if (bad || !body) res.cls = CLS_TEXT;
      else if (point) res.cls = CLS_DECIMAL;
      else res.cls = CLS_INTEGER;
      if (res.cls != CLS_TEXT) begin
        res.mant = neg ? -{1'b0, mag} : {1'b0, mag};
        res.frac = (res.cls == CLS_DECIMAL) ? frac_cnt : 4'd0;
        res.ovf = sat;
      end
      token_results_q.push_back(res);
      at_start = 1'b1;
      neg = 1'b0;
      body = 1'b0;
      point = 1'b0;
      bad = 1'b0;
      mag = '0;
      frac_cnt = '0;
      sat = 1'b0;
    end
  endtask

  task automatic flush_token();
    char_word_t w;
    for (int i = 0; i < tok_buf.size(); i++) begin
      w.ch = tok_buf[i];
      w.last = (i == tok_buf.size() - 1);
      char_q.push_back(w);
    end
    tok_buf.delete();
  endtask

  task automatic add_token(input string s);
    for (int i = 0; i < s.len(); i++) tok_buf.push_back(s[i]);
    flush_token();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_char(in_tdata, in_tlast);
        words_sent <= words_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_tdata <= char_q[0].ch;
          in_tlast <= char_q[0].last;
          in_tvalid <= 1'b1;
          void'(char_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (token_results_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual class %0d data %h",
                   $time, out_tuser, out_tdata);
          errors++;
        end else begin
          token_result_t e;
          e = token_results_q.pop_front();
          if (out_tuser !== e.cls) begin
            $display("%0t: token_class expected %0d actual %0d", $time, e.cls, out_tuser);
            errors++;
          end
          if (out_tdata[31:0] !== e.mant) begin
            $display("%0t: mantissa expected %0d actual %0d", $time,
                     $signed(e.mant), $signed(out_tdata[31:0]));
            errors++;
          end
          if (out_tdata[35:32] !== e.frac) begin
            $display("%0t: fraction_digits expected %0d actual %0d", $time,
                     e.frac, out_tdata[35:32]);
            errors++;
          end
          if (out_tdata[36] !== e.ovf) begin
            $display("%0t: overflow expected %0d actual %0d", $time, e.ovf, out_tdata[36]);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    int sign;
    int int_len;
    int frac_len;
    int has_point;
    int n;

    // directed tokens
    add_token("9");
    add_token("-");
    add_token(".");
    add_token("+.");
    add_token("5.");
    add_token(".5");
    add_token("1.2.");
    tok_buf.push_back(8'h00);
    flush_token();
    tok_buf.push_back(8'hFF);
    flush_token();
    add_token("1-");
    add_token("-3");

    // random tokens: mostly well-formed numbers, some corrupted, some noise
    while (char_q.size() < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        sign = $urandom_range(0, 2);
        if (sign == 1) tok_buf.push_back(CH_PLUS);
        if (sign == 2) tok_buf.push_back(CH_MINUS);
        int_len = (r >= 60 && r < 75) ? $urandom_range(10, 14) : $urandom_range(0, 4);
        has_point = $urandom_range(0, 1);
        frac_len = 0;
        if (has_point != 0)
          frac_len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 3);
        if (int_len == 0 && has_point == 0) int_len = 1;
        repeat (int_len) tok_buf.push_back(rand_digit());
        if (has_point != 0) tok_buf.push_back(CH_POINT);
        repeat (frac_len) tok_buf.push_back(rand_digit());
        if (r >= 75) begin
          n = $urandom_range(0, tok_buf.size() - 1);
          case ($urandom_range(0, 3))
            0: tok_buf[n] = CH_PLUS;
            1: tok_buf[n] = CH_MINUS;
            2: tok_buf[n] = CH_POINT;
            default: tok_buf[n] = 8'($urandom_range(0, 255));
          endcase
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) tok_buf.push_back(8'($urandom_range(0, 255)));
      end
      flush_token();
    end
    total_words = char_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (char_q.size() != 0 || in_tvalid) @(negedge clk);
    while (token_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dtcc_pkg.sv
rtl/dtcc_front.sv
rtl/dtcc_queue.sv
rtl/dtcc_back.sv
rtl/decimal_token_classify_convert.sv
rtl/dtcc_checker.sv
tb/sv/testbench.sv
